>>> hw/rtl/scan_result_dedup_table_unit_macros.svh
// Assertion helpers for the scan result dedup table
`ifndef SCAN_RESULT_DEDUP_TABLE_UNIT_MACROS_SVH
`define SCAN_RESULT_DEDUP_TABLE_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define SRDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SRDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/srdt_pkg.sv
package srdt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic signed [7:0] START_LEVEL = -8'sd127;

  localparam logic [1:0] KIND_REPORT  = 2'd0;
  localparam logic [1:0] KIND_READOUT = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         addr_type;
    logic [47:0]        device_addr;
    logic [7:0]         adv_code;
    logic signed [7:0]  signal_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         out_addr_type;
    logic [47:0]        out_addr;
    logic signed [7:0]  best_level;
    logic               can_connect;
    logic               is_summary;
    logic [15:0]        seen_total;
    logic [15:0]        overflow_total;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         addr_type;
    logic [47:0]        addr;
    logic signed [7:0]  level;
    logic               conn;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic cnt_inc;
    logic update;
    logic clear;
    logic load_entry;
    logic load_summary;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic slot_valid;
    logic pend_busy;
    logic out_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_RD_SUM
  } state_t;

endpackage

>>> hw/rtl/srdt_ctrl.sv
module srdt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_kind,
  output logic            in_ready,
  input  srdt_pkg::sts_t  sts,
  output srdt_pkg::cmd_t  cmd
);
  import srdt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_kind)
            KIND_REPORT:  state_nxt = ST_SCAN;
            KIND_READOUT: state_nxt = ST_RD_ISSUE;
            KIND_CLEAR:   cmd.clear = 1'b1;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!sts.cnt_done) begin
          cmd.scan_step = 1'b1;
        end else if (!sts.pend_busy) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        if (sts.cnt_done) begin
          state_nxt = ST_RD_SUM;
        end else if (sts.slot_valid) begin
          state_nxt = ST_RD_WAIT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_RD_WAIT: begin
        if (sts.out_free) begin
          cmd.load_entry = 1'b1;
          cmd.cnt_inc    = 1'b1;
          state_nxt      = ST_RD_ISSUE;
        end
      end
      ST_RD_SUM: begin
        if (sts.out_free) begin
          cmd.load_summary = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/srdt_datapath.sv
module srdt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  srdt_pkg::in_word_t  in_data,
  input  srdt_pkg::cmd_t      cmd,
  output srdt_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output srdt_pkg::out_word_t out_data
);
  import srdt_pkg::*;

  entry_t                  mem [TABLE_DEPTH];
  entry_t                  rd_data_r;
  logic [TABLE_DEPTH-1:0]  valid_r;
  logic [15:0]             count_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        cnt_idx;
  in_word_t                item_r;
  logic                    pend_vld_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic signed [7:0]       hit_level_r;
  logic                    free_r;
  logic [IDX_W-1:0]        free_idx_r;
  logic                    out_valid_r;
  out_word_t               out_data_r;

  logic                    hit_now;
  logic                    free_now;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  entry_t                  wr_entry;
  logic signed [7:0]       base_level;
  logic [15:0]             ovf;

  assign cnt_idx = cnt_r[IDX_W-1:0];

  assign hit_now = pend_vld_r && !hit_r && valid_r[pend_idx_r]
                   && (rd_data_r.addr_type == item_r.addr_type)
                   && (rd_data_r.addr == item_r.device_addr);
  assign free_now = pend_vld_r && !free_r && !valid_r[pend_idx_r];

  // merge the report into the hit entry or a fresh slot
  assign base_level         = hit_r ? hit_level_r : START_LEVEL;
  assign wr_en              = cmd.update && (hit_r || free_r);
  assign wr_idx             = hit_r ? hit_idx_r : free_idx_r;
  assign wr_entry.addr_type = item_r.addr_type;
  assign wr_entry.addr      = item_r.device_addr;
  assign wr_entry.level     = (item_r.signal_level > base_level) ? item_r.signal_level
                                                                 : base_level;
  assign wr_entry.conn      = (item_r.adv_code[7:1] == 7'd0);

  assign ovf = (count_r > 16'(TABLE_DEPTH)) ? (count_r - 16'(TABLE_DEPTH)) : 16'd0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_data_r <= mem[cnt_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_vld_r <= cmd.scan_step;
      if (cmd.capture) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (cmd.scan_step || cmd.cnt_inc) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (hit_now) begin
          hit_r <= 1'b1;
        end
        if (free_now) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.clear) begin
        valid_r <= '0;
        count_r <= '0;
      end else if (cmd.update && !hit_r) begin
        if (free_r) begin
          valid_r[free_idx_r] <= 1'b1;
        end
        if (count_r != 16'hFFFF) begin
          count_r <= count_r + 16'd1;
        end
      end
      if (cmd.load_entry || cmd.load_summary) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    pend_idx_r <= cnt_idx;
    if (hit_now) begin
      hit_idx_r   <= pend_idx_r;
      hit_level_r <= rd_data_r.level;
    end
    if (free_now) begin
      free_idx_r <= pend_idx_r;
    end
    if (cmd.load_entry) begin
      out_data_r.out_addr_type  <= rd_data_r.addr_type;
      out_data_r.out_addr       <= rd_data_r.addr;
      out_data_r.best_level     <= rd_data_r.level;
      out_data_r.can_connect    <= rd_data_r.conn;
      out_data_r.is_summary     <= 1'b0;
      out_data_r.seen_total     <= 16'd0;
      out_data_r.overflow_total <= 16'd0;
      out_data_r.last           <= 1'b0;
    end else if (cmd.load_summary) begin
      out_data_r.out_addr_type  <= 2'd0;
      out_data_r.out_addr       <= 48'd0;
      out_data_r.best_level     <= 8'sd0;
      out_data_r.can_connect    <= 1'b0;
      out_data_r.is_summary     <= 1'b1;
      out_data_r.seen_total     <= count_r;
      out_data_r.overflow_total <= ovf;
      out_data_r.last           <= 1'b1;
    end
  end

  assign sts.cnt_done   = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign sts.slot_valid = valid_r[cnt_idx];
  assign sts.pend_busy  = pend_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/scan_result_dedup_table_unit.sv
// Scan result dedup table: 16 slots of (type, address, best level, connectable)
// held in a small RAM with registered read, plus a valid bit per slot in flops,
// so reset empties the table at once with no clearing pass. A report reads
// every slot in turn and compares each registered read with the report; once
// the last compare lands, the merged entry is written back to the hit slot or
// a free one. A readout skips empty slots, sends one word per listed slot and
// closes with a summary word, each waiting while the output side stalls. A
// clear empties the table. One item is handled at a time; the output
// register lets the last word of a readout wait while the next item is taken.
`include "scan_result_dedup_table_unit_macros.svh"

module scan_result_dedup_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srdt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srdt_pkg::out_word_t out_data
);
  import srdt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srdt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `SRDT_ASSERT_NEXT(a_report_silent,
                    in_valid && in_ready && (in_data.kind == KIND_REPORT),
                    !$rose(out_valid), "report produced a word")
  `SRDT_ASSERT_NOW(a_last_is_summary,
                   out_valid && (out_data.last != out_data.is_summary),
                   1'b0, "last and summary flags disagree")
  `SRDT_ASSERT_NOW(a_ovf_zero,
                   out_valid && out_data.is_summary && (out_data.seen_total <= 16'(TABLE_DEPTH)),
                   out_data.overflow_total == 16'd0, "overflow without excess")

endmodule
